### src/slpd_pkg.sv
// Shared types and constants of the sync/length/checksum packet deframer.
package slpd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 6;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int RESULT_CAP = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FOURTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 3'd4;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 6'd32;

    typedef enum logic [3:0] {
        S_SYNC0,
        S_SYNC1,
        S_SYNC2,
        S_SYNC3,
        S_LEN,
        S_CMD,
        S_DATA,
        S_CHK,
        S_READ,
        S_LOAD
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic ld_len;    // length byte taken and within limit
        logic ld_cmd;    // command byte taken
        logic st_data;   // payload byte taken
        logic hunt_clr;  // back to hunting: clear checksum and byte count
        logic rd_start;  // checksum matched: rewind read pointer
        logic out_load;  // load one result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [3:0] sync_hit;  // incoming byte equals sync byte k
        logic       len_ok;    // incoming byte within length limit
        logic       len_zero;  // stored frame length is zero
        logic       data_last; // this payload byte completes the frame
        logic       chk_ok;    // incoming byte equals running OR
        logic       rd_last;   // result being read is the final one
        logic       out_free;  // output register can take a result now
    } t_sts;

endpackage

### src/sync_length_packet_deframer_unit.sv
// Rate: header and payload bytes are taken one per cycle while the frame is parsed.
// After the checksum transfer each result is read from the store in S_READ and
// registered in S_LOAD, which waits while the output register is not free;
// an empty packet releases one result.
// No input byte is taken during the release until the last result is loaded.
// Reset: synchronous, active low; hunting restarts, sync bytes clear, max_length 32.
// The payload store is not cleared; every entry read is written earlier in its frame.
module sync_length_packet_deframer_unit
    import slpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    // received byte stream
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    // packet result stream
    output logic                 o_pkt_valid,
    input  logic                 i_pkt_ready,
    output logic [BYTE_W-1:0]    o_pkt_command,
    output logic [LEN_W-1:0]     o_pkt_length,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic                 o_payload_valid,
    output logic [IDX_W-1:0]     o_payload_index,
    output logic                 o_last_of_packet
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Controller: sync hunt, length/command/data/checksum phases, release sequence
    slpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_sts      (w_sts),
        .o_rx_ready (o_rx_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath: checksum OR, frame fields, payload store and the result register.
    // The result register lets the next frame start while the last result waits.
    slpd_dpath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_rx_byte        (i_rx_byte),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_pkt_ready      (i_pkt_ready),
        .o_pkt_valid      (o_pkt_valid),
        .o_pkt_command    (o_pkt_command),
        .o_pkt_length     (o_pkt_length),
        .o_payload_byte   (o_payload_byte),
        .o_payload_valid  (o_payload_valid),
        .o_payload_index  (o_payload_index),
        .o_last_of_packet (o_last_of_packet)
    );

    // A result is never loaded over one that has not been transferred
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result register overwritten");

    // After the final result of a packet the block goes back to hunting
    a_hunt_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load && w_sts.rd_last |=> o_rx_ready)
        else $error("not hunting after last result");

    // Release starts only on a matching checksum byte transfer
    a_release_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_start |-> (w_sts.chk_ok && i_rx_valid && o_rx_ready))
        else $error("release without checksum match");

    // No input transfer while results of a packet are being released
    a_no_take_in_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_start |=> !o_rx_ready)
        else $error("input taken during release");

endmodule

### src/slpd_ctrl.sv
// Controller state machine: frame parsing and result release sequencing.
module slpd_ctrl
    import slpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_rx_valid,
    input  t_sts i_sts,
    output logic o_rx_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SYNC0;
        end else begin
            r_state <= n_state;
        end
    end

    logic w_take;
    assign w_take = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_rx_ready = 1'b0;
        unique case (r_state)
            S_SYNC0: begin
                o_rx_ready = 1'b1;
                if (w_take) n_state = i_sts.sync_hit[0] ? S_SYNC1 : S_SYNC0;
            end
            S_SYNC1: begin
                o_rx_ready = 1'b1;
                if (w_take) n_state = i_sts.sync_hit[1] ? S_SYNC2 : S_SYNC0;
            end
            S_SYNC2: begin
                o_rx_ready = 1'b1;
                if (w_take) n_state = i_sts.sync_hit[2] ? S_SYNC3 : S_SYNC0;
            end
            S_SYNC3: begin
                o_rx_ready = 1'b1;
                if (w_take) n_state = i_sts.sync_hit[3] ? S_LEN : S_SYNC0;
            end
            S_LEN: begin
                o_rx_ready = 1'b1;
                if (w_take) begin
                    if (i_sts.len_ok) begin
                        o_cmd.ld_len = 1'b1;
                        n_state      = S_CMD;
                    end else begin
                        o_cmd.hunt_clr = 1'b1;
                        n_state        = S_SYNC0;
                    end
                end
            end
            S_CMD: begin
                o_rx_ready = 1'b1;
                if (w_take) begin
                    o_cmd.ld_cmd = 1'b1;
                    n_state      = i_sts.len_zero ? S_CHK : S_DATA;
                end
            end
            S_DATA: begin
                o_rx_ready = 1'b1;
                if (w_take) begin
                    o_cmd.st_data = 1'b1;
                    if (i_sts.data_last) n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_rx_ready = 1'b1;
                if (w_take) begin
                    o_cmd.hunt_clr = 1'b1;
                    if (i_sts.chk_ok) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_READ;
                    end else begin
                        n_state = S_SYNC0;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_sts.rd_last ? S_SYNC0 : S_READ;
                end
            end
            default: begin
                n_state = S_SYNC0;
            end
        endcase
    end

endmodule

### src/slpd_dpath.sv
// Datapath: config registers, checksum, frame fields, payload store, output register.
module slpd_dpath
    import slpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_pkt_ready,
    output logic                 o_pkt_valid,
    output logic [BYTE_W-1:0]    o_pkt_command,
    output logic [LEN_W-1:0]     o_pkt_length,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic                 o_payload_valid,
    output logic [IDX_W-1:0]     o_payload_index,
    output logic                 o_last_of_packet
);

    localparam int DEPTH = (MAX_PAYLOAD > RESULT_CAP) ? RESULT_CAP : MAX_PAYLOAD;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LEN_W-1:0] CAP = LEN_W'(DEPTH);

    // configuration
    logic [BYTE_W-1:0] r_sync [4];
    logic [LEN_W-1:0]  r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync[0] <= '0;
            r_sync[1] <= '0;
            r_sync[2] <= '0;
            r_sync[3] <= '0;
            r_max_len <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_sync[0] <= i_cfg_wdata;
                CFG_SYNC_SECOND: r_sync[1] <= i_cfg_wdata;
                CFG_SYNC_THIRD:  r_sync[2] <= i_cfg_wdata;
                CFG_SYNC_FOURTH: r_sync[3] <= i_cfg_wdata;
                CFG_MAX_LENGTH:  r_max_len <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // frame state
    logic [BYTE_W-1:0] r_running_or;
    logic [LEN_W-1:0]  r_frame_len;
    logic [BYTE_W-1:0] r_frame_cmd;
    logic [LEN_W-1:0]  r_bytes_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_or  <= '0;
            r_frame_len   <= '0;
            r_frame_cmd   <= '0;
            r_bytes_taken <= '0;
        end else begin
            if (i_cmd.hunt_clr) begin
                r_running_or  <= '0;
                r_bytes_taken <= '0;
            end else begin
                if (i_cmd.ld_len || i_cmd.ld_cmd || i_cmd.st_data) begin
                    r_running_or <= r_running_or | i_rx_byte;
                end
                if (i_cmd.ld_len) begin
                    r_bytes_taken <= '0;
                end else if (i_cmd.st_data) begin
                    r_bytes_taken <= r_bytes_taken + LEN_W'(1);
                end
            end
            if (i_cmd.ld_len) r_frame_len <= i_rx_byte[LEN_W-1:0];
            if (i_cmd.ld_cmd) r_frame_cmd <= i_rx_byte;
        end
    end

    // payload store, single write and single registered read
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]     r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_data) r_mem[r_bytes_taken[AW-1:0]] <= i_rx_byte;
        r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_ptr <= '0;
        end else if (i_cmd.out_load) begin
            r_rd_ptr <= r_rd_ptr + AW'(1);
        end
    end

    // status
    logic [LEN_W-1:0] w_limit;
    assign w_limit = (r_max_len > CAP) ? CAP : r_max_len;

    always_comb begin
        o_sts.sync_hit[0] = (i_rx_byte == r_sync[0]);
        o_sts.sync_hit[1] = (i_rx_byte == r_sync[1]);
        o_sts.sync_hit[2] = (i_rx_byte == r_sync[2]);
        o_sts.sync_hit[3] = (i_rx_byte == r_sync[3]);
        o_sts.len_ok      = (i_rx_byte <= BYTE_W'(w_limit));
        o_sts.len_zero    = (r_frame_len == '0);
        o_sts.data_last   = ((LEN_W + 1)'(r_bytes_taken) + (LEN_W + 1)'(1))
                            == (LEN_W + 1)'(r_frame_len);
        o_sts.chk_ok      = (i_rx_byte == r_running_or);
        o_sts.rd_last     = (r_frame_len == '0)
                            || ((LEN_W'(r_rd_ptr) + LEN_W'(1)) == r_frame_len);
        o_sts.out_free    = !o_pkt_valid || i_pkt_ready;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pkt_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_pkt_valid <= 1'b1;
        end else if (i_pkt_ready) begin
            o_pkt_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pkt_command    <= r_frame_cmd;
            o_pkt_length     <= r_frame_len;
            o_payload_valid  <= (r_frame_len != '0);
            o_payload_byte   <= (r_frame_len == '0) ? '0 : r_rd_data;
            o_payload_index  <= (r_frame_len == '0) ? '0 : IDX_W'(r_rd_ptr);
            o_last_of_packet <= o_sts.rd_last;
        end
    end

endmodule

### verif/testbench.sv
// Testbench for the sync/length/checksum packet deframer: directed, register and random tests.
module testbench;
    import slpd_pkg::*;

    localparam int MAX_PAYLOAD    = 32;
    localparam int RANDOM_ITEMS   = 64;
    // Longest quiet stretch in a correct run is a sender gap or a receiver stall
    // plus the release of a result; this is many times that.
    localparam int WATCHDOG_LIMIT = 500;
    // A byte that yields no result leaves nothing for the block to release.
    localparam int SETTLE_CYCLES  = 8;

    // One decoded packet result, laid out as the output ports
    typedef struct packed {
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
        logic              data_valid;
        logic [IDX_W-1:0]  index;
        logic              last;
    } t_pkt_result;

    // ---------------------------------------------------------------- ports
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [BYTE_W-1:0]    i_cfg_wdata = '0;
    logic                 i_rx_valid  = 1'b0;
    logic                 o_rx_ready;
    logic [BYTE_W-1:0]    i_rx_byte   = '0;
    logic                 o_pkt_valid;
    logic                 i_pkt_ready = 1'b0;
    logic [BYTE_W-1:0]    o_pkt_command;
    logic [LEN_W-1:0]     o_pkt_length;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic                 o_payload_valid;
    logic [IDX_W-1:0]     o_payload_index;
    logic                 o_last_of_packet;

    sync_length_packet_deframer_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------ deframer model
    // Register copies, at their reset values
    logic [BYTE_W-1:0] sync_word [4] = '{default: 8'h00};
    logic [LEN_W-1:0]  max_len_reg   = MAX_LENGTH_RST;

    // Parser state, at its reset values
    t_state            parse_state = S_SYNC0;
    logic [BYTE_W-1:0] or_sum      = '0;
    logic [LEN_W-1:0]  frame_len   = '0;
    logic [BYTE_W-1:0] frame_cmd   = '0;
    logic [LEN_W-1:0]  taken       = '0;
    logic [BYTE_W-1:0] frame_data [MAX_PAYLOAD];

    t_pkt_result decoded_packets [$];

    // Run statistics
    int unsigned rx_sent      = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes   = 0;
    int unsigned frames_data  = 0;
    int unsigned frames_empty = 0;
    int unsigned chk_drops    = 0;
    int unsigned len_aborts   = 0;
    int unsigned mismatch_count = 0;

    // Traffic shaping
    bit          sender_idle_on = 1'b0;
    int unsigned burst_left     = 0;
    bit          ready_stall_on = 1'b0;
    logic [15:0] stall_pattern  = 16'hFFFF;
    logic [3:0]  stall_pos      = '0;

    // Effective length bound: register value clipped to the store and result cap
    function automatic int unsigned len_ceiling();
        int unsigned lim;
        lim = 32'(max_len_reg);
        if (lim > MAX_PAYLOAD) lim = MAX_PAYLOAD;
        if (lim > RESULT_CAP) lim = RESULT_CAP;
        return lim;
    endfunction

    // Advance the parser by one accepted byte; queue any packet results it releases
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        t_pkt_result r;
        int unsigned n;
        case (parse_state)
            // A mismatch drops back to the first sync byte without retesting it
            S_SYNC0: parse_state = (b == sync_word[0]) ? S_SYNC1 : S_SYNC0;
            S_SYNC1: parse_state = (b == sync_word[1]) ? S_SYNC2 : S_SYNC0;
            S_SYNC2: parse_state = (b == sync_word[2]) ? S_SYNC3 : S_SYNC0;
            S_SYNC3: parse_state = (b == sync_word[3]) ? S_LEN : S_SYNC0;
            S_LEN: begin
                if (b > len_ceiling()) begin
                    // Over-long frame: abort, and the checksum restarts too
                    parse_state = S_SYNC0;
                    or_sum      = '0;
                    taken       = '0;
                    len_aborts++;
                end else begin
                    frame_len   = b[LEN_W-1:0];
                    or_sum      = or_sum | b;
                    taken       = '0;
                    parse_state = S_CMD;
                end
            end
            S_CMD: begin
                frame_cmd   = b;
                or_sum      = or_sum | b;
                // Empty payload goes straight to the checksum
                parse_state = (frame_len == 0) ? S_CHK : S_DATA;
            end
            S_DATA: begin
                if (taken < frame_len) begin
                    frame_data[taken[IDX_W-1:0]] = b;
                    taken  = taken + 1'b1;
                    or_sum = or_sum | b;
                end
                if (taken >= frame_len) parse_state = S_CHK;
            end
            default: begin
                if (b == or_sum) begin
                    n = 32'(frame_len);
                    if (n == 0) begin
                        r = '{command: frame_cmd, length: '0, data: '0,
                              data_valid: 1'b0, index: '0, last: 1'b1};
                        decoded_packets.push_back(r);
                        frames_empty++;
                    end else begin
                        for (int k = 0; k < n; k++) begin
                            r.command    = frame_cmd;
                            r.length     = n[LEN_W-1:0];
                            r.data       = frame_data[k];
                            r.data_valid = 1'b1;
                            r.index      = k[IDX_W-1:0];
                            r.last       = (k == n - 1);
                            decoded_packets.push_back(r);
                        end
                        frames_data++;
                    end
                end else begin
                    chk_drops++;
                end
                // Whatever the checksum, hunting restarts
                parse_state = S_SYNC0;
                or_sum      = '0;
                taken       = '0;
            end
        endcase
    endfunction

    // ------------------------------------------------------ receive side
    // Ready follows a rotating stall pattern; bit 0 is always set so no stall
    // lasts longer than the pattern length.
    always @(negedge i_clk) begin
        if (!ready_stall_on) begin
            i_pkt_ready <= 1'b1;
        end else begin
            i_pkt_ready <= stall_pattern[stall_pos];
        end
        stall_pos <= stall_pos + 1'b1;
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Every result transfer is matched against the oldest decoded packet byte
    always @(posedge i_clk) begin : check_results
        t_pkt_result want;
        if (i_rst_n && o_pkt_valid && i_pkt_ready) begin
            if (decoded_packets.size() == 0) begin
                $error("result transfer with nothing outstanding: command %0d index %0d",
                       o_pkt_command, o_payload_index);
                mismatch_count++;
            end else begin
                want = decoded_packets.pop_front();
                check_field("pkt_command",    32'(want.command),    32'(o_pkt_command));
                check_field("pkt_length",     32'(want.length),     32'(o_pkt_length));
                check_field("payload_byte",   32'(want.data),       32'(o_payload_byte));
                check_field("payload_valid",  32'(want.data_valid), 32'(o_payload_valid));
                check_field("payload_index",  32'(want.index),      32'(o_payload_index));
                check_field("last_of_packet", 32'(want.last),       32'(o_last_of_packet));
                results_seen++;
            end
        end
    end

    // Watchdog: any transfer or register write resets the quiet count
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_pkt_valid && i_pkt_ready)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, decoded_packets.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------ send side
    // One byte transfer. With gaps on, the sender runs in bursts; at the end of a burst
    // valid drops for a random gap. Valid stays high between bytes of a burst.
    task automatic send_rx(input logic [BYTE_W-1:0] value);
        int unsigned gap;
        if (sender_idle_on && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
            burst_left = $urandom_range(1, 16);
            @(negedge i_clk);
            i_rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_rx_valid <= 1'b1;
        i_rx_byte  <= value;
        do @(posedge i_clk); while (!o_rx_ready);
        deframe_byte(value);
        rx_sent++;
    endtask

    // Drop valid, then wait for every outstanding result plus a short settle
    task automatic settle();
        @(negedge i_clk);
        i_rx_valid <= 1'b0;
        while (decoded_packets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Called only once the block is idle; picks sender gaps and a fresh stall pattern
    task automatic set_traffic(input bit idle_on);
        sender_idle_on = idle_on;
        burst_left     = 0;
        ready_stall_on = idle_on;
        stall_pattern  = 16'(($urandom_range(0, 1) ? $urandom : ($urandom & $urandom)) | 1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] wdata);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= wdata;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  sync_word[0] = wdata;
            CFG_SYNC_SECOND: sync_word[1] = wdata;
            CFG_SYNC_THIRD:  sync_word[2] = wdata;
            CFG_SYNC_FOURTH: sync_word[3] = wdata;
            CFG_MAX_LENGTH:  max_len_reg  = wdata[LEN_W-1:0];
            default: ;  // unmapped index: ignored
        endcase
        cfg_writes++;
    endtask

    task automatic set_sync(input logic [BYTE_W-1:0] s0, input logic [BYTE_W-1:0] s1,
                            input logic [BYTE_W-1:0] s2, input logic [BYTE_W-1:0] s3);
        write_reg(CFG_SYNC_FIRST,  s0);
        write_reg(CFG_SYNC_SECOND, s1);
        write_reg(CFG_SYNC_THIRD,  s2);
        write_reg(CFG_SYNC_FOURTH, s3);
    endtask

    // A full frame with random command and data. A length over the bound stops
    // after the length byte, since the block has gone back to hunting.
    task automatic send_frame(input int unsigned len, input bit chk_good);
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] d;
        cmd = BYTE_W'($urandom);
        chk = len[BYTE_W-1:0] | cmd;
        for (int k = 0; k < 4; k++) send_rx(sync_word[k]);
        send_rx(len[BYTE_W-1:0]);
        if (len <= len_ceiling()) begin
            send_rx(cmd);
            repeat (len) begin
                d   = BYTE_W'($urandom);
                chk = chk | d;
                send_rx(d);
            end
            if (!chk_good) chk = chk ^ BYTE_W'($urandom_range(1, 255));
            send_rx(chk);
        end
    endtask

    // ------------------------------------------------------ tests
    // Reset values: all-zero sync pattern and a 32-byte bound
    task automatic test_reset_defaults();
        set_traffic(1'b0);
        // empty packet, command 0
        repeat (7) send_rx(8'h00);
        // one data byte; checksum 01 | 42 | 99
        repeat (4) send_rx(8'h00);
        send_rx(8'h01);
        send_rx(8'h42);
        send_rx(8'h99);
        send_rx(8'hDB);
        settle();
    endtask

    task automatic test_directed_cases();
        set_sync(8'hA5, 8'h5A, 8'hC3, 8'h3C);
        set_traffic(1'b1);
        // repeated first sync byte: the second A5 breaks the pattern and is
        // not taken as a new start, so the rest is just hunted over
        send_rx(8'hA5); send_rx(8'hA5); send_rx(8'h5A); send_rx(8'hC3); send_rx(8'h3C);
        // length 33 over the bound: abort
        send_rx(8'hA5); send_rx(8'h5A); send_rx(8'hC3); send_rx(8'h3C); send_rx(8'h21);
        // empty packet straight after the abort; checksum must not carry 0x21
        send_rx(8'hA5); send_rx(8'h5A); send_rx(8'hC3); send_rx(8'h3C);
        send_rx(8'h00); send_rx(8'hFF); send_rx(8'hFF);
        // bad checksum: expected FF, sent 00, dropped silently
        send_rx(8'hA5); send_rx(8'h5A); send_rx(8'hC3); send_rx(8'h3C);
        send_rx(8'h01); send_rx(8'h00); send_rx(8'hFF); send_rx(8'h00);
        settle();
    endtask

    task automatic test_register_extremes();
        set_traffic(1'b1);
        // bound 0: only empty packets pass
        set_sync(8'h00, 8'h00, 8'h00, 8'h00);
        write_reg(CFG_MAX_LENGTH, 8'h00);
        send_frame(0, 1'b1);
        send_frame(1, 1'b1);
        send_frame(0, 1'b0);
        settle();
        // register 63 acts as the 32-byte store limit
        set_sync(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        write_reg(CFG_MAX_LENGTH, 8'hFF);
        send_frame(32, 1'b1);
        send_frame(33, 1'b1);
        send_frame(2, 1'b0);
        settle();
        // writes to unmapped indexes change nothing
        for (int idx = CFG_MAX_LENGTH + 1; idx < (1 << CFG_IDX_W); idx++) begin
            write_reg(idx[CFG_IDX_W-1:0], 8'hFF);
        end
        send_frame(5, 1'b1);
        send_frame(3, 1'b1);
        settle();
        // bound 1
        set_sync(8'h12, 8'h34, 8'h56, 8'h78);
        write_reg(CFG_MAX_LENGTH, 8'h01);
        send_frame(1, 1'b1);
        send_frame(2, 1'b1);
        send_frame(0, 1'b1);
        settle();
    endtask

    // Mostly well-formed frames with random content, plus broken sync and noise.
    // Four rounds, each with its own registers and traffic shape.
    task automatic test_random_traffic();
        int unsigned start;
        int unsigned ceil_len;
        int unsigned len;
        int unsigned pick;
        int unsigned depth;
        logic [BYTE_W-1:0] shared;
        logic [BYTE_W-1:0] wrong;
        for (int rnd = 0; rnd < 4; rnd++) begin
            // first round runs flat out, the rest with gaps and stalls
            set_traffic(rnd != 0);
            if ($urandom_range(0, 3) == 0) begin
                // identical sync bytes: self-overlapping pattern
                shared = BYTE_W'($urandom);
                set_sync(shared, shared, shared, shared);
            end else begin
                set_sync(BYTE_W'($urandom), BYTE_W'($urandom),
                         BYTE_W'($urandom), BYTE_W'($urandom));
            end
            pick = $urandom_range(0, 3);
            if (pick == 0) write_reg(CFG_MAX_LENGTH, BYTE_W'($urandom));
            else if (pick == 1) write_reg(CFG_MAX_LENGTH, 8'd32);
            else write_reg(CFG_MAX_LENGTH, BYTE_W'($urandom_range(0, 12)));
            ceil_len = len_ceiling();
            start = rx_sent;
            while (rx_sent - start < RANDOM_ITEMS / 4) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    // short lengths dominate; the bound and just past it now and then
                    pick = $urandom_range(0, 99);
                    if (pick < 55) len = $urandom_range(0, (ceil_len < 6) ? ceil_len : 6);
                    else if (pick < 80) len = $urandom_range(0, ceil_len);
                    else if (pick < 90) len = ceil_len;
                    else if (pick < 96) len = ceil_len + 1;
                    else len = $urandom_range(ceil_len + 1, 255);
                    send_frame(len, $urandom_range(0, 99) < 85);
                end else if (pick < 88) begin
                    // partial sync pattern then a wrong byte
                    depth = $urandom_range(1, 3);
                    for (int k = 0; k < depth; k++) send_rx(sync_word[k]);
                    wrong = BYTE_W'($urandom);
                    if (wrong == sync_word[depth]) wrong = ~wrong;
                    send_rx(wrong);
                end else begin
                    repeat ($urandom_range(1, 6)) send_rx(BYTE_W'($urandom));
                end
            end
            settle();
        end
    endtask

    // ------------------------------------------------------ sequence
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_register_extremes();
        test_random_traffic();

        $display("run: %0d bytes in, %0d result transfers, %0d register writes",
                 rx_sent, results_seen, cfg_writes);
        $display("frames: %0d with data, %0d empty, %0d bad checksum, %0d over length",
                 frames_data, frames_empty, chk_drops, len_aborts);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
